// File: hdl/chroma_key_matte_top_assert.svh
// Assertion macros shared by the matte pipeline.
`ifndef CHROMA_KEY_MATTE_TOP_ASSERT_SVH
`define CHROMA_KEY_MATTE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CKM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CKM_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define CKM_ASSERT(lbl, prop, msg)
`define CKM_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hdl/ckm_pkg.sv
package ckm_pkg;

   localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [14:0] ACCEPT_MAX = 15'd25736;
   localparam logic [40:0] KFG_CAP = 41'h100_0000_0000;
   localparam logic [15:0] Q15_ONE = 16'd32768;

   localparam logic [1:0] CSR_ACCEPT = 2'd0;
   localparam logic [1:0] CSR_CUTOFF = 2'd1;
   localparam logic [1:0] CSR_GAIN = 2'd2;

   // Item state carried through the second divider.
   typedef struct packed {
      logic [15:0] alpha;
      logic        outside;
      logic        cut;
      logic        mzero;
   } ckm_side_type;

   // Arctangent of 2^-i in Q1.30.
   function automatic logic [30:0] atan_q30(input int i);
      case (i)
         0: return 31'd843314857;
         1: return 31'd497837829;
         2: return 31'd263043837;
         3: return 31'd133525159;
         4: return 31'd67021687;
         5: return 31'd33543516;
         6: return 31'd16775851;
         7: return 31'd8388437;
         8: return 31'd4194283;
         9: return 31'd2097149;
         default: begin
            if (i > 30) return 31'd0;
            else return 31'd1 << (30 - i);
         end
      endcase
   endfunction

endpackage

// File: hdl/ckm_front.sv
module ckm_front import ckm_pkg::*; #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS = 15
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [15:0]                 img_cb,
   input  logic [15:0]                 img_cr,
   input  logic [15:0]                 img_alpha,
   input  logic [15:0]                 key_cb,
   input  logic [15:0]                 key_cr,
   input  logic [14:0]                 acceptance,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+4:0] out_x,
   output logic signed [FRAC_BITS+4:0] out_az,
   output logic signed [31:0]          out_s,
   output logic signed [31:0]          out_c,
   output logic                        out_acc_zero,
   output logic [15:0]                 out_alpha
);
   localparam int CS = CORDIC_STEPS;
   localparam int WI = FRAC_BITS + 3;
   localparam int WC = FRAC_BITS + 6;
   localparam int WX = FRAC_BITS + 5;
   localparam int WP = WC + 32;
   localparam int WA = 33;
   localparam int SHL = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
   localparam int SHR = (FRAC_BITS >= 15) ? 0 : 15 - FRAC_BITS;

   function automatic logic signed [WI-1:0] to_frac(input logic [15:0] v);
      logic signed [18:0]    t;
      logic signed [WI+18:0] w;
      t = signed'({2'b00, v, 1'b0}) - 19'sd32768;
      w = {{WI{t[18]}}, t};
      w = (w <<< SHL) >>> SHR;
      return w[WI-1:0];
   endfunction

   logic signed [WC-1:0] kx_ff [0:CS];
   logic signed [WC-1:0] ky_ff [0:CS];
   logic signed [WC-1:0] ix_ff [0:CS];
   logic signed [WC-1:0] iy_ff [0:CS];
   logic signed [31:0]   c_ff [0:CS];
   logic signed [31:0]   s_ff [0:CS];
   logic signed [WA-1:0] ang_ff [0:CS];
   logic                 zero_ff [0:CS];
   logic                 acc0_ff [0:CS];
   logic [15:0]          alpha_ff [0:CS];
   logic                 valid_ff [0:CS];

   logic signed [WI-1:0] kx0, ky0, ix0, iy0;
   logic signed [WC-1:0] kx_in, ky_in, ix_in, iy_in;
   logic [14:0]          acc;

   always_comb begin
      kx0 = to_frac(key_cb);
      ky0 = to_frac(key_cr);
      ix0 = to_frac(img_cb);
      iy0 = to_frac(img_cr);
      kx_in = {{3{kx0[WI-1]}}, kx0};
      ky_in = {{3{ky0[WI-1]}}, ky0};
      ix_in = {{3{ix0[WI-1]}}, ix0};
      iy_in = {{3{iy0[WI-1]}}, iy0};
      // A key left of the axis is turned by a half turn together with the pixel.
      if (kx0 < 0) begin
         kx_in = -kx_in;
         ky_in = -ky_in;
         ix_in = -ix_in;
         iy_in = -iy_in;
      end
      acc = (acceptance > ACCEPT_MAX) ? ACCEPT_MAX : acceptance;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else if (en) valid_ff[0] <= in_valid;
      if (en) begin
         kx_ff[0] <= kx_in;
         ky_ff[0] <= ky_in;
         ix_ff[0] <= ix_in;
         iy_ff[0] <= iy_in;
         c_ff[0] <= INV_GAIN_Q30;
         s_ff[0] <= 32'sd0;
         ang_ff[0] <= signed'({2'b00, acc, 16'h0000});
         zero_ff[0] <= (kx0 == 0) && (ky0 == 0);
         acc0_ff[0] <= (acc == 15'd0);
         alpha_ff[0] <= img_alpha;
      end
   end

   for (genvar i = 0; i < CS; i++) begin : g_step
      localparam logic signed [WA-1:0] AT = signed'({2'b00, atan_q30(i)});
      logic signed [WC-1:0] kx_in, ky_in, ix_in, iy_in;
      logic signed [31:0]   c_in, s_in;
      logic signed [WA-1:0] ang_in;

      always_comb begin
         // A zero key leaves the pixel as it is.
         if (zero_ff[i]) begin
            kx_in = kx_ff[i];
            ky_in = ky_ff[i];
            ix_in = ix_ff[i];
            iy_in = iy_ff[i];
         end else if (ky_ff[i] > 0) begin
            kx_in = kx_ff[i] + (ky_ff[i] >>> i);
            ky_in = ky_ff[i] - (kx_ff[i] >>> i);
            ix_in = ix_ff[i] + (iy_ff[i] >>> i);
            iy_in = iy_ff[i] - (ix_ff[i] >>> i);
         end else begin
            kx_in = kx_ff[i] - (ky_ff[i] >>> i);
            ky_in = ky_ff[i] + (kx_ff[i] >>> i);
            ix_in = ix_ff[i] - (iy_ff[i] >>> i);
            iy_in = iy_ff[i] + (ix_ff[i] >>> i);
         end
         if (ang_ff[i] >= 0) begin
            c_in = c_ff[i] - (s_ff[i] >>> i);
            s_in = s_ff[i] + (c_ff[i] >>> i);
            ang_in = ang_ff[i] - AT;
         end else begin
            c_in = c_ff[i] + (s_ff[i] >>> i);
            s_in = s_ff[i] - (c_ff[i] >>> i);
            ang_in = ang_ff[i] + AT;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else if (en) valid_ff[i+1] <= valid_ff[i];
         if (en) begin
            kx_ff[i+1] <= kx_in;
            ky_ff[i+1] <= ky_in;
            ix_ff[i+1] <= ix_in;
            iy_ff[i+1] <= iy_in;
            c_ff[i+1] <= c_in;
            s_ff[i+1] <= s_in;
            ang_ff[i+1] <= ang_in;
            zero_ff[i+1] <= zero_ff[i];
            acc0_ff[i+1] <= acc0_ff[i];
            alpha_ff[i+1] <= alpha_ff[i];
         end
      end
   end

   // Gain correction multiply, then the shift and selection.
   logic signed [WP-1:0] mx_ff, my_ff;
   logic signed [WC-1:0] rx_ff, ry_ff;
   logic signed [31:0]   ms_ff, mc_ff;
   logic                 mzero_ff, macc0_ff, mvalid_ff;
   logic [15:0]          malpha_ff;
   logic signed [WP-1:0] mx_in, my_in;

   assign mx_in = WP'(ix_ff[CS]) * WP'(INV_GAIN_Q30);
   assign my_in = WP'(iy_ff[CS]) * WP'(INV_GAIN_Q30);

   always_ff @(posedge clock) begin
      if (reset) mvalid_ff <= 1'b0;
      else if (en) mvalid_ff <= valid_ff[CS];
      if (en) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         rx_ff <= ix_ff[CS];
         ry_ff <= iy_ff[CS];
         ms_ff <= s_ff[CS];
         mc_ff <= c_ff[CS];
         mzero_ff <= zero_ff[CS];
         macc0_ff <= acc0_ff[CS];
         malpha_ff <= alpha_ff[CS];
      end
   end

   logic signed [WP-1:0] sx, sz;
   logic signed [WX-1:0] x_in, z_in, az_in;

   always_comb begin
      sx = mx_ff >>> 30;
      sz = my_ff >>> 30;
      x_in = mzero_ff ? rx_ff[WX-1:0] : sx[WX-1:0];
      z_in = mzero_ff ? ry_ff[WX-1:0] : sz[WX-1:0];
      az_in = (z_in < 0) ? -z_in : z_in;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (en) out_valid <= mvalid_ff;
      if (en) begin
         out_x <= x_in;
         out_az <= az_in;
         out_s <= ms_ff;
         out_c <= mc_ff;
         out_acc_zero <= macc0_ff;
         out_alpha <= malpha_ff;
      end
   end
endmodule

// File: hdl/ckm_beta.sv
module ckm_beta import ckm_pkg::*; #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS = 15
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [FRAC_BITS+4:0] x,
   input  logic signed [FRAC_BITS+4:0] az,
   input  logic [14:0]                 cutoff,
   output logic                        out_valid,
   output logic                        out_cut
);
   localparam int CS = CORDIC_STEPS;
   localparam int WB = FRAC_BITS + 7;
   localparam int WA = 33;

   logic signed [WB-1:0] bx_ff [0:CS];
   logic signed [WB-1:0] by_ff [0:CS];
   logic signed [WA-1:0] ang_ff [0:CS];
   logic                 valid_ff [0:CS];

   logic signed [WB-1:0] xe, ze;
   assign xe = WB'(x);
   assign ze = WB'(az);

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else if (en) valid_ff[0] <= in_valid;
      if (en) begin
         // A vector in the left half plane is turned by a quarter turn first.
         if (x < 0) begin
            bx_ff[0] <= ze;
            by_ff[0] <= -xe;
            ang_ff[0] <= signed'({2'b00, HALF_PI_Q30});
         end else begin
            bx_ff[0] <= xe;
            by_ff[0] <= ze;
            ang_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CS; i++) begin : g_step
      localparam logic signed [WA-1:0] AT = signed'({2'b00, atan_q30(i)});
      logic signed [WB-1:0] bx_in, by_in;
      logic signed [WA-1:0] ang_in;

      always_comb begin
         if (by_ff[i] > 0) begin
            bx_in = bx_ff[i] + (by_ff[i] >>> i);
            by_in = by_ff[i] - (bx_ff[i] >>> i);
            ang_in = ang_ff[i] + AT;
         end else begin
            bx_in = bx_ff[i] - (by_ff[i] >>> i);
            by_in = by_ff[i] + (bx_ff[i] >>> i);
            ang_in = ang_ff[i] - AT;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[i+1] <= 1'b0;
         else if (en) valid_ff[i+1] <= valid_ff[i];
         if (en) begin
            bx_ff[i+1] <= bx_in;
            by_ff[i+1] <= by_in;
            ang_ff[i+1] <= ang_in;
         end
      end
   end

   logic signed [WA-1:0] ang_abs;
   assign ang_abs = (ang_ff[CS] < 0) ? -ang_ff[CS] : ang_ff[CS];
   assign out_cut = ang_abs < signed'({2'b00, cutoff, 16'h0000});
   assign out_valid = valid_ff[CS];
endmodule

// File: hdl/ckm_divider.sv
module ckm_divider #(
   parameter int DW = 52,
   parameter int VW = 31,
   parameter int SW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [DW-1:0] quotient,
   output logic [SW-1:0] out_side
);
   // Restoring division, one quotient bit per stage. The dividend shifts out
   // at the top of rq while quotient bits enter at the bottom.
   logic [VW-1:0] rem_ff [1:DW];
   logic [DW-1:0] rq_ff [1:DW];
   logic [VW-1:0] dv_ff [1:DW];
   logic [SW-1:0] side_ff [1:DW];
   logic          valid_ff [1:DW];

   for (genvar j = 0; j < DW; j++) begin : g_step
      logic [VW-1:0] src_rem, src_dv, rem_in;
      logic [DW-1:0] src_rq, rq_in;
      logic [SW-1:0] src_side;
      logic          src_valid;
      logic [VW:0]   trial, diff;

      if (j == 0) begin : g_first
         assign src_rem = '0;
         assign src_rq = dividend;
         assign src_dv = divisor;
         assign src_side = in_side;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src_rem = rem_ff[j];
         assign src_rq = rq_ff[j];
         assign src_dv = dv_ff[j];
         assign src_side = side_ff[j];
         assign src_valid = valid_ff[j];
      end

      always_comb begin
         trial = {src_rem, src_rq[DW-1]};
         diff = trial - {1'b0, src_dv};
         if (trial >= {1'b0, src_dv}) begin
            rem_in = diff[VW-1:0];
            rq_in = {src_rq[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            rq_in = {src_rq[DW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) valid_ff[j+1] <= 1'b0;
         else if (en) valid_ff[j+1] <= src_valid;
         if (en) begin
            rem_ff[j+1] <= rem_in;
            rq_ff[j+1] <= rq_in;
            dv_ff[j+1] <= src_dv;
            side_ff[j+1] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[DW];
   assign quotient = rq_ff[DW];
   assign out_side = side_ff[DW];
endmodule

// File: hdl/chroma_key_matte_top.sv
// Channel  Handshake               Payload
// req      req_valid / req_stall   img_cb, img_cr, img_alpha, key_cb, key_cr
// rsp      rsp_valid / rsp_stall   matte
// csr      csr_valid / csr_ready   csr_index, csr_data
//
// One word enters per clock while the output is not stalled; each word passes
// through the hue CORDIC and the two bit-per-stage dividers.
// Reset is synchronous; it clears only the valid bits and loads the control registers with their defaults.
// A stalled result freezes the whole pipeline, so req_stall follows rsp_stall
// only while a word is waiting at the output.
`include "chroma_key_matte_top_assert.svh"
module chroma_key_matte_top import ckm_pkg::*; #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_img_cb,
   input  logic [15:0] req_img_cr,
   input  logic [15:0] req_img_alpha,
   input  logic [15:0] req_key_cb,
   input  logic [15:0] req_key_cr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_matte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int WX = FRAC_BITS + 5;
   localparam int WM = WX + 32;
   localparam int WN = WM + 1;
   localparam int DW = WN - 1;
   localparam int LD = DW - (CORDIC_STEPS + 1);
   localparam int SHL = (FRAC_BITS >= 15) ? 0 : 15 - FRAC_BITS;
   localparam int SHR = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
   localparam int SW2 = $bits(ckm_side_type);

   logic [14:0] accept_ff, cutoff_ff;
   logic [15:0] gain_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_matte_ff;
   logic        en;

   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_matte = rsp_matte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_ff <= 15'd2744;
         cutoff_ff <= 15'd858;
         gain_ff <= 16'd32768;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ACCEPT: accept_ff <= csr_data[14:0];
            CSR_CUTOFF: cutoff_ff <= csr_data[14:0];
            CSR_GAIN:   gain_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   logic                 f_valid, f_acc0;
   logic signed [WX-1:0] f_x, f_az;
   logic signed [31:0]   f_s, f_c;
   logic [15:0]          f_alpha;

   ckm_front #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid),
      .img_cb(req_img_cb), .img_cr(req_img_cr), .img_alpha(req_img_alpha),
      .key_cb(req_key_cb), .key_cr(req_key_cr), .acceptance(accept_ff),
      .out_valid(f_valid), .out_x(f_x), .out_az(f_az), .out_s(f_s), .out_c(f_c),
      .out_acc_zero(f_acc0), .out_alpha(f_alpha)
   );

   // Products of the acceptance test.
   logic signed [WM-1:0] p_xs_ff, p_ac_ff;
   logic signed [WX-1:0] p_x_ff, p_az_ff;
   logic signed [31:0]   p_s_ff;
   logic                 p_acc0_ff, p_valid_ff;
   logic [15:0]          p_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) p_valid_ff <= 1'b0;
      else if (en) p_valid_ff <= f_valid;
      if (en) begin
         p_xs_ff <= WM'(f_x) * WM'(f_s);
         p_ac_ff <= WM'(f_az) * WM'(f_c);
         p_x_ff <= f_x;
         p_az_ff <= f_az;
         p_s_ff <= f_s;
         p_acc0_ff <= f_acc0;
         p_alpha_ff <= f_alpha;
      end
   end

   logic signed [WN-1:0] num_in;
   logic                 outside_in;
   logic [DW-1:0]        q_num_ff;
   logic [30:0]          q_div_ff;
   logic signed [WX-1:0] q_x_ff, q_az_ff;
   logic                 q_out_ff, q_valid_ff;
   logic [15:0]          q_alpha_ff;

   assign num_in = WN'(p_xs_ff) - WN'(p_ac_ff);
   assign outside_in = p_acc0_ff || (p_s_ff <= 0) || (num_in <= 0);

   always_ff @(posedge clock) begin
      if (reset) q_valid_ff <= 1'b0;
      else if (en) q_valid_ff <= p_valid_ff;
      if (en) begin
         q_num_ff <= num_in[DW-1:0];
         q_div_ff <= p_s_ff[30:0];
         q_x_ff <= p_x_ff;
         q_az_ff <= p_az_ff;
         q_out_ff <= outside_in;
         q_alpha_ff <= p_alpha_ff;
      end
   end

   logic          d1_valid;
   logic [DW-1:0] d1_q;
   logic [16:0]   d1_side;

   ckm_divider #(.DW(DW), .VW(31), .SW(17)) u_div_kfg (
      .clock(clock), .reset(reset), .en(en), .in_valid(q_valid_ff),
      .dividend(q_num_ff), .divisor(q_div_ff), .in_side({q_alpha_ff, q_out_ff}),
      .out_valid(d1_valid), .quotient(d1_q), .out_side(d1_side)
   );

   logic b_valid, b_cut;

   ckm_beta #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_beta (
      .clock(clock), .reset(reset), .en(en), .in_valid(q_valid_ff),
      .x(q_x_ff), .az(q_az_ff), .cutoff(cutoff_ff),
      .out_valid(b_valid), .out_cut(b_cut)
   );

   // The cutoff flag waits here for the quotient of the same word.
   logic dl_cut_ff [0:LD-1];
   logic dl_valid_ff [0:LD-1];

   always_ff @(posedge clock) begin
      if (reset) dl_valid_ff[0] <= 1'b0;
      else if (en) dl_valid_ff[0] <= b_valid;
      if (en) dl_cut_ff[0] <= b_cut;
   end

   for (genvar k = 1; k < LD; k++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) dl_valid_ff[k] <= 1'b0;
         else if (en) dl_valid_ff[k] <= dl_valid_ff[k-1];
         if (en) dl_cut_ff[k] <= dl_cut_ff[k-1];
      end
   end

   logic [40:0]  kcap;
   logic [47:0]  kq;
   ckm_side_type k_side_in, k_side_ff;
   logic [15:0]  k_kfg_ff;
   logic         k_valid_ff;

   always_comb begin
      kcap = (d1_q > DW'(KFG_CAP)) ? KFG_CAP : d1_q[40:0];
      kq = ({7'b0, kcap} << SHL) >> SHR;
      k_side_in.alpha = d1_side[16:1];
      k_side_in.outside = d1_side[0];
      k_side_in.cut = dl_cut_ff[LD-1];
      k_side_in.mzero = (gain_ff == 16'd0) || (kq >= {32'b0, gain_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) k_valid_ff <= 1'b0;
      else if (en) k_valid_ff <= d1_valid;
      if (en) begin
         k_kfg_ff <= kq[15:0];
         k_side_ff <= k_side_in;
      end
   end

   logic           d2_valid;
   logic [30:0]    d2_q;
   logic [SW2-1:0] d2_side_raw;
   ckm_side_type   d2_side;

   ckm_divider #(.DW(31), .VW(16), .SW(SW2)) u_div_matte (
      .clock(clock), .reset(reset), .en(en), .in_valid(k_valid_ff),
      .dividend({k_kfg_ff, 15'd0}), .divisor(gain_ff), .in_side(k_side_ff),
      .out_valid(d2_valid), .quotient(d2_q), .out_side(d2_side_raw)
   );

   assign d2_side = ckm_side_type'(d2_side_raw);

   logic [15:0] matte_in;

   always_comb begin
      if (d2_side.mzero || d2_side.cut) matte_in = 16'd0;
      else matte_in = Q15_ONE - d2_q[15:0];
      if (matte_in > d2_side.alpha) matte_in = d2_side.alpha;
      if (d2_side.outside) matte_in = d2_side.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= d2_valid;
      if (en) rsp_matte_ff <= matte_in;
   end

   `CKM_ASSERT(a_cut_aligned, dl_valid_ff[LD-1] == d1_valid, "cutoff flag out of step")
   `CKM_ASSERT_NEXT(a_matte_bound, !reset && en && d2_valid, rsp_matte_ff <= $past(d2_side.alpha), "matte above alpha")
   `CKM_ASSERT_NEXT(a_outside_pass, !reset && en && d2_valid && d2_side.outside, rsp_matte_ff == $past(d2_side.alpha), "outside word not passed")
   `CKM_ASSERT_NEXT(a_zero_matte, !reset && en && d2_valid && !d2_side.outside && (d2_side.mzero || d2_side.cut), rsp_matte_ff == 16'd0, "matte not cleared")
endmodule
